/* rtl/tcm_pkg.sv */
`default_nettype none

package tcm_pkg;

   localparam int SampleWidth   = 12;
   localparam int PressWidth    = SampleWidth + 1;
   localparam int InsetWidth    = 11;
   localparam int BoundsWidth   = 2 * SampleWidth;
   localparam int OpWidth       = SampleWidth + 1;
   localparam int ProdWidth     = 2 * OpWidth;
   localparam int MagWidth      = 2 * SampleWidth;
   localparam int SumWidth      = MagWidth + 2;
   localparam int CountWidth    = $clog2(MagWidth);
   localparam int PointCount    = 4;
   localparam int JobCount      = 4;
   localparam int JobIdxWidth   = $clog2(JobCount);

   localparam int RegCount      = 7;
   localparam int AddrWidth     = $clog2(RegCount * 4);
   localparam int RegIdxWidth   = AddrWidth - 2;
   localparam int DataWidth     = 32;

   localparam int FullScale     = 4095;
   localparam int MinPressure   = 100;
   localparam int Thirds        = 3;
   localparam int ThirdMin      = (FullScale + Thirds - 1) / Thirds;
   localparam int ThirdMax      = (2 * FullScale + Thirds - 1) / Thirds;

   localparam logic [SampleWidth-1:0] UnsetPoint = 12'h7FF;

   localparam logic [SampleWidth-1:0] PanelWidthReset  = 12'd320;
   localparam logic [SampleWidth-1:0] PanelHeightReset = 12'd240;
   localparam logic [InsetWidth-1:0]  AlignInsetReset  = 11'd20;
   localparam logic [BoundsWidth-1:0] BoundsReset      = 24'hFFF000;

   localparam int PtXMin = 0;
   localparam int PtXMax = 1;
   localparam int PtYMin = 2;
   localparam int PtYMax = 3;

   localparam int InvXBit = 0;
   localparam int InvYBit = 1;

   typedef enum logic [RegIdxWidth-1:0] {
      REG_ROTATION,
      REG_INVERT_MODE,
      REG_PANEL_WIDTH,
      REG_PANEL_HEIGHT,
      REG_ALIGN_INSET,
      REG_X_BOUNDS,
      REG_Y_BOUNDS
   } reg_index_type;

   typedef enum logic [1:0] {
      ROT_0,
      ROT_90,
      ROT_180,
      ROT_270
   } rotation_type;

   typedef enum logic [1:0] {
      KIND_READ,
      KIND_ALIGN,
      KIND_START
   } kind_type;

   typedef struct packed {
      rotation_type             rotation;
      logic [1:0]               invert_mode;
      logic [SampleWidth-1:0]   panel_width;
      logic [SampleWidth-1:0]   panel_height;
      logic [InsetWidth-1:0]    align_inset;
      logic [BoundsWidth-1:0]   x_bounds;
      logic [BoundsWidth-1:0]   y_bounds;
      logic                     load_x;
      logic                     load_y;
   } cfg_type;

   typedef struct packed {
      logic signed [OpWidth-1:0] mul_a;
      logic signed [OpWidth-1:0] mul_b;
      logic signed [OpWidth-1:0] divisor;
      logic [SampleWidth-1:0]    offset;
   } job_type;

   typedef struct packed {
      logic    start;
      job_type job;
   } op_type;

   typedef struct packed {
      logic                   done;
      logic [SampleWidth-1:0] value;
   } res_type;

endpackage

`default_nettype wire

/* rtl/tcm_if.sv */
`default_nettype none

interface tcm_req_if;
   import tcm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [SampleWidth-1:0] z1_sample;
   logic [SampleWidth-1:0] z2_sample;
   logic [SampleWidth-1:0] x_sample;
   logic [SampleWidth-1:0] y_sample;

   modport source (output valid, kind, z1_sample, z2_sample, x_sample, y_sample,
                   input ready);
   modport sink (input valid, kind, z1_sample, z2_sample, x_sample, y_sample,
                 output ready);
endinterface

interface tcm_rsp_if;
   import tcm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] screen_x;
   logic [SampleWidth-1:0] screen_y;
   logic [PressWidth-1:0]  pressure;
   logic                   touch_valid;
   logic                   align_ready;

   modport source (output valid, screen_x, screen_y, pressure, touch_valid, align_ready,
                   input ready);
   modport sink (input valid, screen_x, screen_y, pressure, touch_valid, align_ready,
                 output ready);
endinterface

`default_nettype wire

/* rtl/tcm_csr.sv */
`default_nettype none

module tcm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcm_pkg::AddrWidth-1:0]   paddr,
   input  logic [tcm_pkg::DataWidth-1:0]   pwdata,
   output logic [tcm_pkg::DataWidth-1:0]   prdata,
   output logic                            pready,
   output tcm_pkg::cfg_type                cfg
);
   import tcm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          write_strobe;

   assign reg_idx      = reg_index_type'(paddr[AddrWidth-1:2]);
   assign write_strobe = psel && penable && pwrite;
   assign pready       = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in        = cfg_ff;
      cfg_in.load_x = 1'b0;
      cfg_in.load_y = 1'b0;
      if (write_strobe) begin
         case (reg_idx)
            REG_ROTATION:     cfg_in.rotation     = rotation_type'(pwdata[1:0]);
            REG_INVERT_MODE:  cfg_in.invert_mode  = pwdata[1:0];
            REG_PANEL_WIDTH:  cfg_in.panel_width  = pwdata[SampleWidth-1:0];
            REG_PANEL_HEIGHT: cfg_in.panel_height = pwdata[SampleWidth-1:0];
            REG_ALIGN_INSET:  cfg_in.align_inset  = pwdata[InsetWidth-1:0];
            REG_X_BOUNDS: begin
               cfg_in.x_bounds = pwdata[BoundsWidth-1:0];
               cfg_in.load_x   = 1'b1;
            end
            REG_Y_BOUNDS: begin
               cfg_in.y_bounds = pwdata[BoundsWidth-1:0];
               cfg_in.load_y   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ROTATION:     prdata = DataWidth'(cfg_ff.rotation);
         REG_INVERT_MODE:  prdata = DataWidth'(cfg_ff.invert_mode);
         REG_PANEL_WIDTH:  prdata = DataWidth'(cfg_ff.panel_width);
         REG_PANEL_HEIGHT: prdata = DataWidth'(cfg_ff.panel_height);
         REG_ALIGN_INSET:  prdata = DataWidth'(cfg_ff.align_inset);
         REG_X_BOUNDS:     prdata = DataWidth'(cfg_ff.x_bounds);
         REG_Y_BOUNDS:     prdata = DataWidth'(cfg_ff.y_bounds);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation     <= ROT_0;
         cfg_ff.invert_mode  <= 2'b00;
         cfg_ff.panel_width  <= PanelWidthReset;
         cfg_ff.panel_height <= PanelHeightReset;
         cfg_ff.align_inset  <= AlignInsetReset;
         cfg_ff.x_bounds     <= BoundsReset;
         cfg_ff.y_bounds     <= BoundsReset;
         cfg_ff.load_x       <= 1'b0;
         cfg_ff.load_y       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tcm_arith.sv */
`default_nettype none

module tcm_arith (
   input  logic             clock,
   input  logic             reset,
   input  tcm_pkg::op_type  op,
   output tcm_pkg::res_type res
);
   import tcm_pkg::*;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_ABS,
      A_DIV,
      A_FIX
   } state_type;

   state_type                     state_ff, state_in;
   job_type                       job_ff, job_in;
   logic signed [ProdWidth-1:0]   prod_ff, prod_in;
   logic [MagWidth-1:0]           quo_ff, quo_in;
   logic [SampleWidth-1:0]        rem_ff, rem_in;
   logic [SampleWidth-1:0]        den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic                          done_ff, done_in;
   logic [SampleWidth-1:0]        value_ff, value_in;

   logic signed [ProdWidth-1:0]   prod_abs;
   logic signed [OpWidth-1:0]     den_abs;
   logic [SampleWidth:0]          trial;
   logic [SampleWidth:0]          diff;
   logic signed [SumWidth-1:0]    offset_ext;
   logic signed [SumWidth-1:0]    quo_ext;
   logic signed [SumWidth-1:0]    sum;

   assign res.done  = done_ff;
   assign res.value = value_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      value_in = value_ff;

      prod_abs   = prod_ff[ProdWidth-1] ? -prod_ff : prod_ff;
      den_abs    = job_ff.divisor[OpWidth-1] ? -job_ff.divisor : job_ff.divisor;
      trial      = {rem_ff, quo_ff[MagWidth-1]};
      diff       = trial - {1'b0, den_ff};
      offset_ext = $signed({{(SumWidth-SampleWidth){1'b0}}, job_ff.offset});
      quo_ext    = $signed({{(SumWidth-MagWidth){1'b0}}, quo_ff});
      sum        = neg_ff ? offset_ext - quo_ext : offset_ext + quo_ext;

      case (state_ff)
         A_IDLE: begin
            if (op.start) begin
               job_in   = op.job;
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            prod_in  = job_ff.mul_a * job_ff.mul_b;
            state_in = A_ABS;
         end
         A_ABS: begin
            quo_in   = prod_abs[MagWidth-1:0];
            den_in   = den_abs[SampleWidth-1:0];
            neg_in   = prod_ff[ProdWidth-1] ^ job_ff.divisor[OpWidth-1];
            rem_in   = '0;
            count_in = CountWidth'(MagWidth - 1);
            if (job_ff.divisor == '0) begin
               value_in = job_ff.offset;
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = diff[SampleWidth-1:0];
               quo_in = {quo_ff[MagWidth-2:0], 1'b1};
            end else begin
               rem_in = trial[SampleWidth-1:0];
               quo_in = {quo_ff[MagWidth-2:0], 1'b0};
            end
            if (count_ff == '0) begin
               state_in = A_FIX;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         A_FIX: begin
            if (sum < 0) begin
               value_in = '0;
            end else if (sum > $signed(SumWidth'(FullScale))) begin
               value_in = '1;
            end else begin
               value_in = sum[SampleWidth-1:0];
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      job_ff   <= job_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* rtl/tcm_seq.sv */
`default_nettype none

module tcm_seq (
   input  logic             clock,
   input  logic             reset,
   input  tcm_pkg::cfg_type cfg,
   tcm_req_if.sink          req_if,
   tcm_rsp_if.source        rsp_if,
   output tcm_pkg::op_type  op,
   input  tcm_pkg::res_type res
);
   import tcm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECORD,
      S_PLAN,
      S_ISSUE,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   logic [SampleWidth-1:0]   rx_ff, rx_in;
   logic [SampleWidth-1:0]   ry_ff, ry_in;
   logic [PressWidth-1:0]    press_ff, press_in;
   logic                     touch_ff, touch_in;
   logic [SampleWidth-1:0]   sx_ff, sx_in;
   logic [SampleWidth-1:0]   sy_ff, sy_in;
   logic [JobCount-1:0]      mask_ff, mask_in;
   logic [JobIdxWidth-1:0]   idx_ff, idx_in;
   logic [SampleWidth-1:0]   bound_ff [PointCount];
   logic [SampleWidth-1:0]   bound_in [PointCount];
   logic [SampleWidth-1:0]   point_ff [PointCount];
   logic [SampleWidth-1:0]   point_in [PointCount];
   logic                     out_valid_ff, out_valid_in;
   logic [SampleWidth-1:0]   out_x_ff, out_x_in;
   logic [SampleWidth-1:0]   out_y_ff, out_y_in;
   logic [PressWidth-1:0]    out_press_ff, out_press_in;
   logic                     out_touch_ff, out_touch_in;
   logic                     out_align_ff, out_align_in;

   logic                     rot_odd;
   logic [SampleWidth-1:0]   cols;
   logic [SampleWidth-1:0]   rows;
   logic [SampleWidth-1:0]   xi;
   logic [SampleWidth-1:0]   yi;
   logic [SampleWidth-1:0]   rx_calc;
   logic [SampleWidth-1:0]   ry_calc;
   logic [PressWidth-1:0]    press_calc;
   kind_type                 req_kind;
   logic                     x_known;
   logic                     y_known;
   logic                     x_update;
   logic                     y_update;
   logic                     use_y;
   logic [SampleWidth-1:0]   v_sel;
   logic [SampleWidth-1:0]   lo_sel;
   logic [SampleWidth-1:0]   hi_sel;
   logic [SampleWidth-1:0]   span_sel;

   assign rot_odd = (cfg.rotation == ROT_90) || (cfg.rotation == ROT_270);
   assign cols    = rot_odd ? cfg.panel_height : cfg.panel_width;
   assign rows    = rot_odd ? cfg.panel_width : cfg.panel_height;

   assign req_kind   = kind_type'(req_if.kind);
   assign xi         = cfg.invert_mode[InvXBit] ? ~req_if.x_sample : req_if.x_sample;
   assign yi         = cfg.invert_mode[InvYBit] ? ~req_if.y_sample : req_if.y_sample;
   assign press_calc = {1'b0, req_if.z1_sample} + {1'b0, ~req_if.z2_sample};

   always_comb begin
      case (cfg.rotation)
         ROT_0: begin
            rx_calc = yi;
            ry_calc = ~xi;
         end
         ROT_90: begin
            rx_calc = ~xi;
            ry_calc = ~yi;
         end
         ROT_180: begin
            rx_calc = ~yi;
            ry_calc = xi;
         end
         default: begin
            rx_calc = xi;
            ry_calc = yi;
         end
      endcase
   end

   assign x_known = (point_ff[PtXMin] != UnsetPoint) && (point_ff[PtXMax] != UnsetPoint);
   assign y_known = (point_ff[PtYMin] != UnsetPoint) && (point_ff[PtYMax] != UnsetPoint);

   // An axis whose sample falls in the center third leaves its bounds alone.
   assign x_update = x_known && ((rx_ff < SampleWidth'(ThirdMin)) ||
                                 (rx_ff >= SampleWidth'(ThirdMax)));
   assign y_update = y_known && ((ry_ff < SampleWidth'(ThirdMin)) ||
                                 (ry_ff >= SampleWidth'(ThirdMax)));

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.screen_x    = out_x_ff;
   assign rsp_if.screen_y    = out_y_ff;
   assign rsp_if.pressure    = out_press_ff;
   assign rsp_if.touch_valid = out_touch_ff;
   assign rsp_if.align_ready = out_align_ff;

   // Read items use the low index bit to pick the axis, alignment items the high bit.
   always_comb begin
      use_y    = (kind_ff == KIND_READ) ? idx_ff[0] : idx_ff[1];
      v_sel    = use_y ? ry_ff : rx_ff;
      span_sel = use_y ? rows : cols;
      if (kind_ff == KIND_READ) begin
         lo_sel = use_y ? bound_ff[PtYMin] : bound_ff[PtXMin];
         hi_sel = use_y ? bound_ff[PtYMax] : bound_ff[PtXMax];
      end else begin
         lo_sel = use_y ? point_ff[PtYMin] : point_ff[PtXMin];
         hi_sel = use_y ? point_ff[PtYMax] : point_ff[PtXMax];
      end

      op.start = (state_ff == S_ISSUE) && mask_ff[idx_ff];
      if (kind_ff == KIND_READ) begin
         op.job.mul_a   = $signed({1'b0, v_sel}) - $signed({1'b0, lo_sel});
         op.job.mul_b   = $signed({1'b0, span_sel});
         op.job.divisor = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
         op.job.offset  = '0;
      end else begin
         if (idx_ff[0]) begin
            op.job.mul_a = $signed({1'b0, span_sel}) - $signed({2'b00, cfg.align_inset});
         end else begin
            op.job.mul_a = -$signed({2'b00, cfg.align_inset});
         end
         op.job.mul_b   = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
         op.job.divisor = $signed({1'b0, span_sel}) - $signed({1'b0, cfg.align_inset, 1'b0});
         op.job.offset  = lo_sel;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      press_in     = press_ff;
      touch_in     = touch_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mask_in      = mask_ff;
      idx_in       = idx_ff;
      bound_in     = bound_ff;
      point_in     = point_ff;
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_press_in = out_press_ff;
      out_touch_in = out_touch_ff;
      out_align_in = out_align_ff;

      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in = req_kind;
               rx_in   = rx_calc;
               ry_in   = ry_calc;
               sx_in   = '0;
               sy_in   = '0;
               if (req_kind == KIND_READ || req_kind == KIND_ALIGN) begin
                  press_in = press_calc;
                  touch_in = (press_calc >= PressWidth'(MinPressure));
               end else begin
                  press_in = '0;
                  touch_in = 1'b0;
               end
               state_in = S_RECORD;
            end
         end
         S_RECORD: begin
            case (kind_ff)
               KIND_ALIGN: begin
                  if (touch_ff) begin
                     if (rx_ff < SampleWidth'(ThirdMin)) begin
                        point_in[PtXMin] = rx_ff;
                     end else if (rx_ff >= SampleWidth'(ThirdMax)) begin
                        point_in[PtXMax] = rx_ff;
                     end
                     if (ry_ff < SampleWidth'(ThirdMin)) begin
                        point_in[PtYMin] = ry_ff;
                     end else if (ry_ff >= SampleWidth'(ThirdMax)) begin
                        point_in[PtYMax] = ry_ff;
                     end
                  end
               end
               KIND_START: begin
                  for (int i = 0; i < PointCount; i++) begin
                     point_in[i] = UnsetPoint;
                  end
               end
               default: ;
            endcase
            state_in = S_PLAN;
         end
         S_PLAN: begin
            case (kind_ff)
               KIND_READ:  mask_in = 4'b0011;
               KIND_ALIGN: mask_in = touch_ff ? {y_update, y_update, x_update, x_update}
                                              : 4'b0000;
               default:    mask_in = 4'b0000;
            endcase
            idx_in   = '0;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (mask_ff[idx_ff]) begin
               state_in = S_WAIT;
            end else if (idx_ff == JobIdxWidth'(JobCount - 1)) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_WAIT: begin
            if (res.done) begin
               if (kind_ff == KIND_READ) begin
                  if (idx_ff[0]) begin
                     sy_in = res.value;
                  end else begin
                     sx_in = res.value;
                  end
               end else begin
                  for (int i = 0; i < PointCount; i++) begin
                     if (idx_ff == JobIdxWidth'(i)) begin
                        bound_in[i] = res.value;
                     end
                  end
               end
               if (idx_ff == JobIdxWidth'(JobCount - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               out_x_in     = sx_ff;
               out_y_in     = sy_ff;
               out_press_in = press_ff;
               out_touch_in = touch_ff;
               out_align_in = x_known && y_known;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg.load_x) begin
         bound_in[PtXMin] = cfg.x_bounds[SampleWidth-1:0];
         bound_in[PtXMax] = cfg.x_bounds[BoundsWidth-1:SampleWidth];
      end
      if (cfg.load_y) begin
         bound_in[PtYMin] = cfg.y_bounds[SampleWidth-1:0];
         bound_in[PtYMax] = cfg.y_bounds[BoundsWidth-1:SampleWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         bound_ff[PtXMin] <= BoundsReset[SampleWidth-1:0];
         bound_ff[PtXMax] <= BoundsReset[BoundsWidth-1:SampleWidth];
         bound_ff[PtYMin] <= BoundsReset[SampleWidth-1:0];
         bound_ff[PtYMax] <= BoundsReset[BoundsWidth-1:SampleWidth];
         for (int i = 0; i < PointCount; i++) begin
            point_ff[i] <= UnsetPoint;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bound_ff     <= bound_in;
         point_ff     <= point_in;
      end
      kind_ff      <= kind_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      press_ff     <= press_in;
      touch_ff     <= touch_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      mask_ff      <= mask_in;
      idx_ff       <= idx_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_press_ff <= out_press_in;
      out_touch_ff <= out_touch_in;
      out_align_ff <= out_align_in;
   end

endmodule

`default_nettype wire

/* rtl/touch_coordinate_mapper.sv */
// Resistive touch sample mapper: every transfer on the request channel carries one set of
// Z1, Z2, X and Y conversions and yields exactly one transfer on the response channel, in
// order. The block works on one item at a time and drops req ready until that item's result
// sits in the output register; a finished result may wait there while the next item is taken.
// All scaling goes through one shared multiply and restoring-divide unit that produces one
// quotient bit per cycle over 24 bits. A read item takes two scalings, an alignment touch up
// to four when both axes recompute their bounds, and other items none. Registers are to be
// written through the APB port only while the block is idle; the block itself does not enforce
// this. Writing x_bounds or y_bounds reloads the working bounds of that axis.
`default_nettype none

module touch_coordinate_mapper (
   input  logic                          clock,
   input  logic                          reset,
   tcm_req_if.sink                       req_if,
   tcm_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tcm_pkg::AddrWidth-1:0] paddr,
   input  logic [tcm_pkg::DataWidth-1:0] pwdata,
   output logic [tcm_pkg::DataWidth-1:0] prdata,
   output logic                          pready
);
   import tcm_pkg::*;

   cfg_type cfg;
   op_type  op;
   res_type res;

   tcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcm_arith u_arith (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   tcm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .op     (op),
      .res    (res)
   );

endmodule

`default_nettype wire

/* rtl/tcm_checker.sv */
`default_nettype none

module tcm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tcm_pkg::SampleWidth-1:0]   screen_x,
   input logic [tcm_pkg::SampleWidth-1:0]   screen_y,
   input logic [tcm_pkg::PressWidth-1:0]    pressure,
   input logic                              touch_valid,
   input logic                              align_ready
);
   import tcm_pkg::*;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(screen_x) && $stable(screen_y)
         && $stable(pressure) && $stable(touch_valid) && $stable(align_ready))
      else $error("response changed while stalled");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // The touch flag always agrees with the reported pressure.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (touch_valid == (pressure >= PressWidth'(MinPressure))))
      else $error("touch flag disagrees with pressure");

   // No response is presented right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind touch_coordinate_mapper tcm_checker u_tcm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .screen_x    (rsp_if.screen_x),
   .screen_y    (rsp_if.screen_y),
   .pressure    (rsp_if.pressure),
   .touch_valid (rsp_if.touch_valid),
   .align_ready (rsp_if.align_ready)
);

`default_nettype wire

/* dv/tb_touch_coordinate_mapper.sv */
`timescale 1ns / 1ps

module tb_touch_coordinate_mapper;
   import tcm_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int SettleLimit = 150;
   localparam int PhaseCount  = 8;
   localparam int PhaseItems  = 50;

   localparam logic [1:0] KIND_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]             kind;
      logic [SampleWidth-1:0] z1;
      logic [SampleWidth-1:0] z2;
      logic [SampleWidth-1:0] x;
      logic [SampleWidth-1:0] y;
   } touch_type;

   typedef struct packed {
      logic [SampleWidth-1:0] screen_x;
      logic [SampleWidth-1:0] screen_y;
      logic [PressWidth-1:0]  pressure;
      logic                   touch_valid;
      logic                   align_ready;
   } reading_type;

   logic                   clock;
   logic                   reset;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [AddrWidth-1:0]   paddr;
   logic [DataWidth-1:0]   pwdata;
   logic [DataWidth-1:0]   prdata;
   logic                   pready;

   tcm_req_if req_if ();
   tcm_rsp_if rsp_if ();

   touch_coordinate_mapper i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Mapper state as the block should hold it.
   rotation_type           rot_q;
   logic [1:0]             inv_q;
   logic [SampleWidth-1:0] width_q;
   logic [SampleWidth-1:0] height_q;
   logic [InsetWidth-1:0]  inset_q;
   logic [SampleWidth-1:0] cal_bounds [PointCount];
   logic [SampleWidth-1:0] edge_pts [PointCount];

   touch_type   samples_q [$];
   reading_type screen_points_q [$];
   touch_type   cur_touch;
   reading_type oldest;

   int queued;
   int mismatches;
   int readings_seen;
   int settings;
   int kind_seen [4];
   int gap_left;
   int burst_left;
   int stall_tick;
   int cycle_count;
   logic [31:0] ready_pattern;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint lin_map(longint v, longint a, longint b, longint lo, longint hi);
      if (b == a) return lo;
      return (v - a) * (hi - lo) / (b - a) + lo;
   endfunction

   function automatic logic [SampleWidth-1:0] clamp12(longint v);
      if (v < 0) return '0;
      if (v > FullScale) return SampleWidth'(FullScale);
      return v[SampleWidth-1:0];
   endfunction

   function automatic void update_edge(logic [SampleWidth-1:0] v, int base,
                                       logic [SampleWidth-1:0] span);
      int     third;
      longint lo;
      longint hi;
      longint ins;
      third = (int'(v) * Thirds) / FullScale;
      if (third == 1) return;
      if (third == 0) edge_pts[base] = v;
      else edge_pts[base + 1] = v;
      if (edge_pts[base] == UnsetPoint || edge_pts[base + 1] == UnsetPoint) return;
      lo  = longint'(edge_pts[base]);
      hi  = longint'(edge_pts[base + 1]);
      ins = longint'(inset_q);
      cal_bounds[base]     = clamp12(lin_map(0, ins, longint'(span) - ins, lo, hi));
      cal_bounds[base + 1] = clamp12(lin_map(longint'(span), ins, longint'(span) - ins,
                                             lo, hi));
   endfunction

   function automatic reading_type map_touch(touch_type t);
      reading_type            r;
      logic [SampleWidth-1:0] xs;
      logic [SampleWidth-1:0] ys;
      logic [SampleWidth-1:0] rx;
      logic [SampleWidth-1:0] ry;
      logic [SampleWidth-1:0] cols;
      logic [SampleWidth-1:0] rows;
      int                     press;
      logic                   firm;
      r     = '0;
      cols  = rot_q[0] ? height_q : width_q;
      rows  = rot_q[0] ? width_q : height_q;
      press = int'(t.z1) + FullScale - int'(t.z2);
      firm  = press >= MinPressure;
      xs    = inv_q[InvXBit] ? SampleWidth'(FullScale - int'(t.x)) : t.x;
      ys    = inv_q[InvYBit] ? SampleWidth'(FullScale - int'(t.y)) : t.y;
      case (rot_q)
         ROT_0: begin
            rx = ys;
            ry = SampleWidth'(FullScale - int'(xs));
         end
         ROT_90: begin
            rx = SampleWidth'(FullScale - int'(xs));
            ry = SampleWidth'(FullScale - int'(ys));
         end
         ROT_180: begin
            rx = SampleWidth'(FullScale - int'(ys));
            ry = xs;
         end
         default: begin
            rx = xs;
            ry = ys;
         end
      endcase
      case (t.kind)
         KIND_READ: begin
            r.screen_x    = clamp12(lin_map(longint'(rx), longint'(cal_bounds[PtXMin]),
                                            longint'(cal_bounds[PtXMax]), 0, longint'(cols)));
            r.screen_y    = clamp12(lin_map(longint'(ry), longint'(cal_bounds[PtYMin]),
                                            longint'(cal_bounds[PtYMax]), 0, longint'(rows)));
            r.pressure    = PressWidth'(press);
            r.touch_valid = firm;
         end
         KIND_ALIGN: begin
            if (firm) begin
               update_edge(rx, PtXMin, cols);
               update_edge(ry, PtYMin, rows);
            end
            r.pressure    = PressWidth'(press);
            r.touch_valid = firm;
         end
         KIND_START: begin
            for (int i = 0; i < PointCount; i++) edge_pts[i] = UnsetPoint;
         end
         default: begin
         end
      endcase
      r.align_ready = edge_pts[PtXMin] != UnsetPoint && edge_pts[PtXMax] != UnsetPoint &&
                      edge_pts[PtYMin] != UnsetPoint && edge_pts[PtYMax] != UnsetPoint;
      return r;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_ROTATION:     rot_q = rotation_type'(data[1:0]);
         REG_INVERT_MODE:  inv_q = data[1:0];
         REG_PANEL_WIDTH:  width_q = data[SampleWidth-1:0];
         REG_PANEL_HEIGHT: height_q = data[SampleWidth-1:0];
         REG_ALIGN_INSET:  inset_q = data[InsetWidth-1:0];
         REG_X_BOUNDS: begin
            cal_bounds[PtXMin] = data[11:0];
            cal_bounds[PtXMax] = data[23:12];
         end
         REG_Y_BOUNDS: begin
            cal_bounds[PtYMin] = data[11:0];
            cal_bounds[PtYMax] = data[23:12];
         end
         default: begin
         end
      endcase
   endtask

   task automatic push(logic [1:0] k, int z1, int z2, int x, int y);
      touch_type t;
      t.kind = k;
      t.z1   = SampleWidth'(z1);
      t.z2   = SampleWidth'(z2);
      t.x    = SampleWidth'(x);
      t.y    = SampleWidth'(y);
      samples_q.push_back(t);
      queued++;
   endtask

   // Mostly firm touches, with an occasional sample of arbitrary pressure.
   task automatic push_touch(logic [1:0] k, int x, int y);
      int z1;
      int z2;
      int z2_top;
      z1     = int'($urandom_range(0, FullScale));
      z2_top = z1 + FullScale - MinPressure;
      if (z2_top > FullScale) z2_top = FullScale;
      if ($urandom_range(0, 7) == 0) z2 = int'($urandom_range(0, FullScale));
      else z2 = int'($urandom_range(0, z2_top));
      push(k, z1, z2, x, y);
   endtask

   function automatic int edge_sample(bit hi_side);
      return hi_side ? int'($urandom_range(ThirdMax, FullScale))
                     : int'($urandom_range(0, ThirdMin - 1));
   endfunction

   function automatic int any_sample();
      return int'($urandom_range(0, FullScale));
   endfunction

   task automatic drain(int settle);
      do @(negedge clock);
      while (samples_q.size() != 0 || req_if.valid || screen_points_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_phase(int p);
      logic [SampleWidth-1:0] w;
      logic [SampleWidth-1:0] h;
      logic [InsetWidth-1:0]  ins;
      logic [BoundsWidth-1:0] xb;
      logic [BoundsWidth-1:0] yb;
      w   = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                        : 12'($urandom_range(1, 800));
      h   = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                        : 12'($urandom_range(1, 800));
      ins = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 100));
      if ($urandom_range(0, 1) == 0) begin
         xb = 24'($urandom_range(0, 24'hFFFFFF));
         yb = 24'($urandom_range(0, 24'hFFFFFF));
      end else begin
         xb = {12'($urandom_range(3300, 4095)), 12'($urandom_range(0, 800))};
         yb = {12'($urandom_range(3300, 4095)), 12'($urandom_range(0, 800))};
      end
      case (p)
         0: begin
            w   = 12'd1;
            h   = 12'd1;
            ins = '0;
            xb  = '0;
            yb  = '0;
         end
         1: begin
            w   = 12'd4095;
            h   = 12'd4095;
            ins = 11'd2047;
            xb  = 24'hFFFFFF;
            yb  = 24'hFFFFFF;
         end
         2: begin
            w   = 12'd40;
            h   = 12'd40;
            ins = 11'd20;
            xb  = {12'd100, 12'd3900};
         end
         default: begin
         end
      endcase
      write_reg(REG_ROTATION, (p < 4) ? 32'(p) : $urandom_range(0, 3));
      write_reg(REG_INVERT_MODE, (p < 4) ? 32'(3 - p) : $urandom_range(0, 3));
      write_reg(REG_PANEL_WIDTH, 32'(w));
      write_reg(REG_PANEL_HEIGHT, 32'(h));
      write_reg(REG_ALIGN_INSET, 32'(ins));
      if (p < 3 || $urandom_range(0, 2) != 0) begin
         write_reg(REG_X_BOUNDS, 32'(xb));
         write_reg(REG_Y_BOUNDS, 32'(yb));
      end
      settings++;
   endtask

   task automatic push_random_phase();
      int  goal;
      bit  a;
      bit  b;
      goal = queued + PhaseItems;
      while (queued < goal) begin
         case ($urandom_range(0, 9))
            6, 7: begin
               a = 1'($urandom_range(0, 1));
               b = 1'($urandom_range(0, 1));
               push_touch(KIND_START, any_sample(), any_sample());
               push_touch(KIND_ALIGN, edge_sample(a), edge_sample(b));
               push_touch(KIND_ALIGN, edge_sample(!a), edge_sample(!b));
               repeat ($urandom_range(0, 2))
                  push_touch(KIND_ALIGN, edge_sample(1'($urandom_range(0, 1))),
                             edge_sample(1'($urandom_range(0, 1))));
               repeat ($urandom_range(1, 3))
                  push_touch(KIND_READ, any_sample(), any_sample());
            end
            8: begin
               push(2'($urandom_range(0, 3)), any_sample(), any_sample(), any_sample(),
                    any_sample());
            end
            9: begin
               push_touch(KIND_START, any_sample(), any_sample());
               if ($urandom_range(0, 1) == 0)
                  push_touch(KIND_ALIGN, edge_sample(1'($urandom_range(0, 1))),
                             edge_sample(1'($urandom_range(0, 1))));
               else
                  push_touch(KIND_ALIGN, int'($urandom_range(ThirdMin, ThirdMax - 1)),
                             int'($urandom_range(ThirdMin, ThirdMax - 1)));
            end
            default: begin
               push_touch(KIND_READ, any_sample(), any_sample());
            end
         endcase
      end
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     = 0;
         burst_left   = 1;
      end else begin
         if (req_if.valid && req_if.ready) begin
            screen_points_q.push_back(map_touch(cur_touch));
            kind_seen[cur_touch.kind]++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (samples_q.size() != 0) begin
               cur_touch = samples_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.kind      <= cur_touch.kind;
               req_if.z1_sample <= cur_touch.z1;
               req_if.z2_sample <= cur_touch.z2;
               req_if.x_sample  <= cur_touch.x;
               req_if.y_sample  <= cur_touch.y;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = int'($urandom_range(1, 12));
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready follows a random pattern that is redrawn at regular intervals.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_tick    = 0;
         ready_pattern = '1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            readings_seen++;
            if (screen_points_q.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual x=%0d y=%0d", $time,
                        rsp_if.screen_x, rsp_if.screen_y);
               mismatches++;
            end else begin
               oldest = screen_points_q.pop_front();
               check_field("screen_x", int'(oldest.screen_x), int'(rsp_if.screen_x));
               check_field("screen_y", int'(oldest.screen_y), int'(rsp_if.screen_y));
               check_field("pressure", int'(oldest.pressure), int'(rsp_if.pressure));
               check_field("touch_valid", int'(oldest.touch_valid),
                           int'(rsp_if.touch_valid));
               check_field("align_ready", int'(oldest.align_ready),
                           int'(rsp_if.align_ready));
            end
         end
         stall_tick++;
         if (stall_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = $urandom;
               2: ready_pattern = $urandom | $urandom;
               default: ready_pattern = $urandom & $urandom;
            endcase
         end
         rsp_if.ready <= ready_pattern[stall_tick % 32];
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_if.valid       = 1'b0;
      req_if.kind        = '0;
      req_if.z1_sample   = '0;
      req_if.z2_sample   = '0;
      req_if.x_sample    = '0;
      req_if.y_sample    = '0;
      rsp_if.ready       = 1'b0;
      rot_q              = ROT_0;
      inv_q              = '0;
      width_q            = PanelWidthReset;
      height_q           = PanelHeightReset;
      inset_q            = AlignInsetReset;
      cal_bounds[PtXMin] = BoundsReset[11:0];
      cal_bounds[PtXMax] = BoundsReset[23:12];
      cal_bounds[PtYMin] = BoundsReset[11:0];
      cal_bounds[PtYMax] = BoundsReset[23:12];
      for (int i = 0; i < PointCount; i++) edge_pts[i] = UnsetPoint;
      queued        = 0;
      mismatches    = 0;
      readings_seen = 0;
      settings      = 1;
      for (int i = 0; i < 4; i++) kind_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings.
      push(KIND_READ, 4095, 0, 0, 0);
      push(KIND_READ, 0, 4095, 4095, 4095);
      push(KIND_READ, 0, 3996, 2048, 1000);
      push(KIND_READ, 0, 3995, 1000, 2048);
      push(KIND_IGNORED, 4095, 0, 4095, 4095);
      push(KIND_START, 4095, 0, 4095, 0);
      push(KIND_ALIGN, 4095, 0, 2000, 2000);
      push(KIND_ALIGN, 0, 4095, 0, 0);
      push(KIND_ALIGN, 3000, 100, 100, 100);
      push(KIND_ALIGN, 3000, 100, 4000, 4000);
      push(KIND_ALIGN, 3000, 100, 100, 4000);
      push(KIND_READ, 2500, 500, 1364, 2730);
      push(KIND_READ, 2500, 500, 2729, 1365);
      push(KIND_READ, 2500, 500, 0, 4095);
      push(KIND_IGNORED, 0, 0, 0, 0);
      push(KIND_START, 0, 0, 0, 0);
      push(KIND_ALIGN, 4095, 4095, 4095, 0);
      push(KIND_ALIGN, 4095, 4095, 0, 4095);
      push(KIND_READ, 4095, 4095, 4095, 0);
      push(KIND_READ, 4095, 4095, 2048, 2048);
      drain(SettleLimit);

      for (int p = 0; p < PhaseCount; p++) begin
         set_phase(p);
         push_random_phase();
         drain(SettleLimit);
      end

      if (screen_points_q.size() != 0) begin
         $display("%0t: %0d results never arrived, expected none left, actual %0d", $time,
                  screen_points_q.size(), screen_points_q.size());
         mismatches++;
      end
      $display("Sent %0d samples: %0d reads, %0d alignment touches, %0d alignment starts,",
               queued, kind_seen[KIND_READ], kind_seen[KIND_ALIGN], kind_seen[KIND_START]);
      $display("%0d ignored; checked %0d results under %0d register settings, %0d mismatches.",
               kind_seen[KIND_IGNORED], readings_seen, settings, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* touch_coordinate_mapper.f */
rtl/tcm_pkg.sv
rtl/tcm_if.sv
rtl/tcm_csr.sv
rtl/tcm_arith.sv
rtl/tcm_seq.sv
rtl/touch_coordinate_mapper.sv
rtl/tcm_checker.sv
dv/tb_touch_coordinate_mapper.sv
